[rtl/core/svg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package svg_pkg;

    localparam int MAX_RESOLUTION    = 255;
    localparam int CORDIC_ITERATIONS = 16;
    localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS < 24) ? CORDIC_ITERATIONS : 24;
    localparam int CORDIC_CNT_W      = $clog2(CORDIC_STEPS + 1);

    // Width of the divider's dividend and quotient; the divisor is a resolution.
    localparam int DIV_W     = 40;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [2:0] REG_U_RES   = 3'd0;
    localparam logic [2:0] REG_V_RES   = 3'd1;
    localparam logic [2:0] REG_RADIUS  = 3'd2;
    localparam logic [2:0] REG_CTR_X   = 3'd3;
    localparam logic [2:0] REG_CTR_Y   = 3'd4;
    localparam logic [2:0] REG_CTR_Z   = 3'd5;
    localparam logic [2:0] REG_NRM_EN  = 3'd6;
    localparam logic [2:0] REG_TEX_EN  = 3'd7;

    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] eff_res(input logic [7:0] r);
        logic [7:0] v;
        v = (r < 8'd2) ? 8'd2 : r;
        if (int'(v) > MAX_RESOLUTION) begin
            v = 8'(MAX_RESOLUTION);
        end
        return v;
    endfunction

    // Rounded product scaled back from Q2.30 times Q2.30.
    function automatic logic signed [32:0] rnd_unit(input logic signed [67:0] p);
        logic signed [67:0] t;
        t = p + 68'sd536870912;
        return t[62:30];
    endfunction

    // Rounded radius product plus centre, saturated to 32 bits.
    function automatic logic signed [31:0] pos_sat(input logic signed [67:0] p,
                                                   input logic signed [31:0] c);
        logic signed [67:0] t;
        logic signed [35:0] s;
        logic signed [31:0] v;
        t = p + 68'sd536870912;
        s = t[65:30] + 36'(c);
        if (s > 36'sd2147483647) begin
            v = 32'sh7FFFFFFF;
        end else if (s < -36'sd2147483648) begin
            v = 32'sh80000000;
        end else begin
            v = s[31:0];
        end
        return v;
    endfunction

    function automatic logic signed [15:0] nrm_sat(input logic signed [32:0] u);
        logic signed [32:0] t;
        logic signed [17:0] s;
        logic signed [15:0] v;
        t = u + 33'sd16384;
        s = t[32:15];
        if (s > 18'sd32767) begin
            v = 16'sh7FFF;
        end else if (s < -18'sd32768) begin
            v = 16'sh8000;
        end else begin
            v = s[15:0];
        end
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/core/sphere_vertex_generator_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   s_kind, s_row, s_column
// m_        out        m_valid / m_ready   m_pos_*, m_normal_*, m_tex_*, m_is_bounds, m_last
// cfg_      in         cfg_wr_en           cfg_index, cfg_wdata
//
// A vertex item passes, after acceptance, through four divisions on the shared divider
// (start, 40 quotient bits, done), two CORDIC runs of CORDIC_STEPS iterations, six
// multiplier states for the five products of one 34 by 34 multiplier, a box update
// and an output state that holds while the output is stalled.
// A box read gives its two items, the minimum corner and then the maximum corner.
// Reset is synchronous and active low; it restores the registers and empties the box.
// s_ready is high only while the sequencer is idle; a stalled result holds in
// the output register and the next item can be taken while it waits.

module sphere_vertex_generator_unit
    import svg_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_kind,
    input  wire logic [7:0]         s_row,
    input  wire logic [7:0]         s_column,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_pos_x,
    output logic signed [31:0]      m_pos_y,
    output logic signed [31:0]      m_pos_z,
    output logic signed [15:0]      m_normal_x,
    output logic signed [15:0]      m_normal_y,
    output logic signed [15:0]      m_normal_z,
    output logic [16:0]             m_tex_u,
    output logic [16:0]             m_tex_v,
    output logic                    m_is_bounds,
    output logic                    m_last
);

    typedef enum logic [4:0] {
        S_IDLE, S_DTH, S_WTH, S_DPH, S_WPH, S_DTU, S_WTU, S_DTV, S_WTV,
        S_CTH, S_WCTH, S_CPH, S_WCPH, S_M0, S_M1, S_M2, S_M3, S_M4, S_M5,
        S_UPD, S_OUT, S_BOX0, S_BOX1
    } state_t;

    state_t state_reg;

    logic [7:0]         ures_cfg_reg;
    logic [7:0]         vres_cfg_reg;
    logic [31:0]        radius_reg;
    logic signed [31:0] ctr_reg [3];
    logic               nrm_en_reg;
    logic               tex_en_reg;

    logic signed [31:0] min_reg [3];
    logic signed [31:0] max_reg [3];

    logic [7:0]         ures_reg;
    logic [7:0]         vres_reg;
    logic [7:0]         row_reg;
    logic [7:0]         col_reg;
    logic [31:0]        th_reg;
    logic [31:0]        ph_reg;
    logic [16:0]        tu_reg;
    logic [16:0]        tv_reg;
    logic signed [32:0] ct_reg;
    logic signed [32:0] st_reg;
    logic signed [32:0] cp_reg;
    logic signed [32:0] sp_reg;
    logic signed [32:0] ux_reg;
    logic signed [32:0] uz_reg;
    logic signed [31:0] pos_reg [3];
    logic signed [67:0] prod_reg;

    logic               mv_reg;
    logic signed [31:0] mpos_reg [3];
    logic signed [15:0] mnrm_reg [3];
    logic [16:0]        mtu_reg;
    logic [16:0]        mtv_reg;
    logic               mbnd_reg;
    logic               mlast_reg;

    logic               div_start;
    logic [DIV_W-1:0]   div_dividend;
    logic [7:0]         div_divisor;
    logic               div_done;
    logic [DIV_W-1:0]   div_quo;
    logic               cor_start;
    logic [31:0]        cor_angle;
    logic               cor_done;
    logic signed [32:0] cor_cos;
    logic signed [32:0] cor_sin;
    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;
    logic               out_free;
    logic               out_load;
    logic [7:0]         ures_eff;
    logic [7:0]         vres_eff;
    logic [7:0]         row_cl;
    logic [7:0]         col_cl;

    assign ures_eff = eff_res(ures_cfg_reg);
    assign vres_eff = eff_res(vres_cfg_reg);
    assign row_cl   = (s_row > vres_eff) ? vres_eff : s_row;
    assign col_cl   = (s_column > ures_eff) ? ures_eff : s_column;
    assign out_free = !mv_reg || m_ready;
    assign out_load = out_free && (state_reg inside {S_OUT, S_BOX0, S_BOX1});
    assign s_ready  = (state_reg == S_IDLE);

    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = ures_reg;
        case (state_reg)
            S_DTH: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'({row_reg, 31'b0});
                div_divisor  = vres_reg;
            end
            S_DPH: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'({col_reg, 32'b0});
            end
            S_DTU: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'({col_reg, 16'b0} + {17'b0, ures_reg[7:1]});
            end
            S_DTV: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'({row_reg, 16'b0} + {17'b0, vres_reg[7:1]});
                div_divisor  = vres_reg;
            end
            default: begin
            end
        endcase
    end

    assign cor_start = (state_reg == S_CTH) || (state_reg == S_CPH);
    assign cor_angle = (state_reg == S_CTH) ? th_reg : ph_reg;

    always_comb begin
        mul_a = 34'(st_reg);
        mul_b = 34'(cp_reg);
        case (state_reg)
            S_M1: begin
                mul_b = 34'(sp_reg);
            end
            S_M2: begin
                mul_a = $signed({2'b00, radius_reg});
                mul_b = 34'(ux_reg);
            end
            S_M3: begin
                mul_a = $signed({2'b00, radius_reg});
                mul_b = 34'(ct_reg);
            end
            S_M4: begin
                mul_a = $signed({2'b00, radius_reg});
                mul_b = 34'(uz_reg);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    svg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    svg_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_start),
        .angle   (cor_angle),
        .done    (cor_done),
        .cos_out (cor_cos),
        .sin_out (cor_sin)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ures_cfg_reg <= 8'd49;
            vres_cfg_reg <= 8'd49;
            radius_reg   <= 32'd65536;
            ctr_reg[0]   <= '0;
            ctr_reg[1]   <= '0;
            ctr_reg[2]   <= '0;
            nrm_en_reg   <= 1'b1;
            tex_en_reg   <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_U_RES:  ures_cfg_reg <= cfg_wdata[7:0];
                REG_V_RES:  vres_cfg_reg <= cfg_wdata[7:0];
                REG_RADIUS: radius_reg   <= cfg_wdata;
                REG_CTR_X:  ctr_reg[0]   <= $signed(cfg_wdata);
                REG_CTR_Y:  ctr_reg[1]   <= $signed(cfg_wdata);
                REG_CTR_Z:  ctr_reg[2]   <= $signed(cfg_wdata);
                REG_NRM_EN: nrm_en_reg   <= cfg_wdata[0];
                REG_TEX_EN: tex_en_reg   <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg    <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                min_reg[k] <= 32'sh7FFFFFFF;
                max_reg[k] <= 32'sh80000000;
            end
        end else begin
            // A new item may replace one that leaves in the same cycle.
            if (out_load) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        ures_reg  <= ures_eff;
                        vres_reg  <= vres_eff;
                        row_reg   <= row_cl;
                        col_reg   <= col_cl;
                        state_reg <= s_kind ? S_BOX0 : S_DTH;
                    end
                end
                S_DTH: state_reg <= S_WTH;
                S_WTH: begin
                    if (div_done) begin
                        th_reg    <= div_quo[31:0];
                        state_reg <= S_DPH;
                    end
                end
                S_DPH: state_reg <= S_WPH;
                S_WPH: begin
                    if (div_done) begin
                        // A column equal to the resolution wraps to a whole turn, i.e. zero.
                        ph_reg    <= div_quo[31:0];
                        state_reg <= S_DTU;
                    end
                end
                S_DTU: state_reg <= S_WTU;
                S_WTU: begin
                    if (div_done) begin
                        tu_reg    <= div_quo[16:0];
                        state_reg <= S_DTV;
                    end
                end
                S_DTV: state_reg <= S_WTV;
                S_WTV: begin
                    if (div_done) begin
                        tv_reg    <= div_quo[16:0];
                        state_reg <= S_CTH;
                    end
                end
                S_CTH: state_reg <= S_WCTH;
                S_WCTH: begin
                    if (cor_done) begin
                        ct_reg    <= cor_cos;
                        st_reg    <= cor_sin;
                        state_reg <= S_CPH;
                    end
                end
                S_CPH: state_reg <= S_WCPH;
                S_WCPH: begin
                    if (cor_done) begin
                        cp_reg    <= cor_cos;
                        sp_reg    <= cor_sin;
                        state_reg <= S_M0;
                    end
                end
                S_M0: state_reg <= S_M1;
                S_M1: begin
                    ux_reg    <= rnd_unit(prod_reg);
                    state_reg <= S_M2;
                end
                S_M2: begin
                    uz_reg    <= rnd_unit(prod_reg);
                    state_reg <= S_M3;
                end
                S_M3: begin
                    pos_reg[0] <= pos_sat(prod_reg, ctr_reg[0]);
                    state_reg  <= S_M4;
                end
                S_M4: begin
                    pos_reg[1] <= pos_sat(prod_reg, ctr_reg[1]);
                    state_reg  <= S_M5;
                end
                S_M5: begin
                    pos_reg[2] <= pos_sat(prod_reg, ctr_reg[2]);
                    state_reg  <= S_UPD;
                end
                S_UPD: begin
                    for (int k = 0; k < 3; k++) begin
                        if (pos_reg[k] < min_reg[k]) begin
                            min_reg[k] <= pos_reg[k];
                        end
                        if (pos_reg[k] > max_reg[k]) begin
                            max_reg[k] <= pos_reg[k];
                        end
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        mpos_reg[0] <= pos_reg[0];
                        mpos_reg[1] <= pos_reg[1];
                        mpos_reg[2] <= pos_reg[2];
                        mnrm_reg[0] <= nrm_en_reg ? nrm_sat(ux_reg) : 16'sd0;
                        mnrm_reg[1] <= nrm_en_reg ? nrm_sat(ct_reg) : 16'sd0;
                        mnrm_reg[2] <= nrm_en_reg ? nrm_sat(uz_reg) : 16'sd0;
                        mtu_reg     <= tex_en_reg ? tu_reg : 17'd0;
                        mtv_reg     <= tex_en_reg ? tv_reg : 17'd0;
                        mbnd_reg    <= 1'b0;
                        mlast_reg   <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                S_BOX0, S_BOX1: begin
                    if (out_free) begin
                        mpos_reg[0] <= (state_reg == S_BOX0) ? min_reg[0] : max_reg[0];
                        mpos_reg[1] <= (state_reg == S_BOX0) ? min_reg[1] : max_reg[1];
                        mpos_reg[2] <= (state_reg == S_BOX0) ? min_reg[2] : max_reg[2];
                        mnrm_reg[0] <= 16'sd0;
                        mnrm_reg[1] <= 16'sd0;
                        mnrm_reg[2] <= 16'sd0;
                        mtu_reg     <= 17'd0;
                        mtv_reg     <= 17'd0;
                        mbnd_reg    <= 1'b1;
                        mlast_reg   <= (state_reg == S_BOX1);
                        state_reg   <= (state_reg == S_BOX0) ? S_BOX1 : S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid     = mv_reg;
    assign m_pos_x     = mpos_reg[0];
    assign m_pos_y     = mpos_reg[1];
    assign m_pos_z     = mpos_reg[2];
    assign m_normal_x  = mnrm_reg[0];
    assign m_normal_y  = mnrm_reg[1];
    assign m_normal_z  = mnrm_reg[2];
    assign m_tex_u     = mtu_reg;
    assign m_tex_v     = mtv_reg;
    assign m_is_bounds = mbnd_reg;
    assign m_last      = mlast_reg;

endmodule

`default_nettype wire

[rtl/core/svg_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module svg_div
    import svg_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [7:0]       divisor,
    output logic                  done,
    output logic [DIV_W-1:0]      quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [7:0]           rem_reg;
    logic [7:0]           dsr_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [8:0]           trial;
    logic                 fits;

    // Restoring division: one quotient bit per cycle, most significant first.
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                dsr_reg  <= divisor;
                quo_reg  <= dividend;
            end else if (busy_reg) begin
                rem_reg <= fits ? 8'(trial - {1'b0, dsr_reg}) : trial[7:0];
                quo_reg <= {quo_reg[DIV_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[rtl/core/svg_cordic.sv]
`timescale 1ns / 1ps
`default_nettype none

module svg_cordic
    import svg_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [31:0]        angle,
    output logic                    done,
    output logic signed [32:0]      cos_out,
    output logic signed [32:0]      sin_out
);

    logic                    busy_reg;
    logic                    done_reg;
    logic [CORDIC_CNT_W-1:0] cnt_reg;
    logic [1:0]              quad_reg;
    logic signed [33:0]      x_reg;
    logic signed [33:0]      y_reg;
    logic signed [32:0]      z_reg;
    logic signed [32:0]      cos_reg;
    logic signed [32:0]      sin_reg;
    logic [31:0]             shifted;
    logic signed [33:0]      xs;
    logic signed [33:0]      ys;
    logic signed [32:0]      at;

    // The angle is moved by an eighth of a turn so that the top two bits pick
    // the quadrant and the residual lies within one eighth either side.
    assign shifted = angle + 32'h20000000;
    assign xs      = x_reg >>> cnt_reg;
    assign ys      = y_reg >>> cnt_reg;
    assign at      = $signed({1'b0, atan_turn(5'(cnt_reg))});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quad_reg <= shifted[31:30];
                x_reg    <= CORDIC_GAIN;
                y_reg    <= '0;
                z_reg    <= $signed({3'b000, shifted[29:0]}) - 33'sd536870912;
            end else if (busy_reg) begin
                if (cnt_reg == CORDIC_CNT_W'(CORDIC_STEPS)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    case (quad_reg)
                        2'd0: begin
                            cos_reg <= x_reg[32:0];
                            sin_reg <= y_reg[32:0];
                        end
                        2'd1: begin
                            cos_reg <= 33'(-y_reg);
                            sin_reg <= x_reg[32:0];
                        end
                        2'd2: begin
                            cos_reg <= 33'(-x_reg);
                            sin_reg <= 33'(-y_reg);
                        end
                        default: begin
                            cos_reg <= y_reg[32:0];
                            sin_reg <= 33'(-x_reg);
                        end
                    endcase
                end else begin
                    if (z_reg >= 0) begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - at;
                    end else begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + at;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

`default_nettype wire
